// File: rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared sizes, codes and bundle types for the scaled blit with dirty box.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_SCALE  = 4;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  localparam int PIX_W   = 16;
  localparam int POS_W   = 11;
  localparam int LEN_W   = 11;
  localparam int PW_W    = 11;
  localparam int PH_W    = 10;
  localparam int SCALE_W = 3;
  localparam int PROD_W  = LEN_W + SCALE_W;
  localparam int WIDE_W  = PROD_W + 1;

  localparam logic [PIX_W-1:0] PIX_BLACK = 16'h0000;
  localparam logic [PIX_W-1:0] PIX_WHITE = 16'hFFFF;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int IN_BITS     = 2 * POS_W + 2 * LEN_W + PIX_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * COL_W + 2 * ROW_W + PIX_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    REQ_HEADER   = 3'd0,
    REQ_PIXEL    = 3'd1,
    REQ_MONO     = 3'd2,
    REQ_CLEAR    = 3'd3,
    REQ_MARK_ALL = 3'd4,
    REQ_FLUSH    = 3'd5,
    REQ_READ     = 3'd6
  } req_code_t;

  typedef enum logic [1:0] {
    REG_PANEL_WIDTH  = 2'd0,
    REG_PANEL_HEIGHT = 2'd1,
    REG_SCALE        = 2'd2
  } reg_idx_t;

  // effective (limited) configuration
  typedef struct packed {
    logic [PW_W-1:0]    width;
    logic [PH_W-1:0]    height;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [LEN_W-1:0]        rect_w;
    logic [LEN_W-1:0]        rect_h;
    logic [PIX_W-1:0]        pixel_color;
  } req_t;

  typedef struct packed {
    logic             dirty_valid;
    logic [COL_W-1:0] dirty_left;
    logic [ROW_W-1:0] dirty_top;
    logic [COL_W-1:0] dirty_right;
    logic [ROW_W-1:0] dirty_bottom;
    logic [PIX_W-1:0] read_data;
  } res_t;

endpackage

// File: rtl/sbd_ram.sv
// ----------------------------------------------------------------------------
// sbd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/sbd_engine.sv
// ----------------------------------------------------------------------------
// sbd_engine
// Request sequencer: shared scale multiplier, block clipping, dirty box
// merge and the framebuffer fill, sweep and read paths.
// ----------------------------------------------------------------------------
module sbd_engine import sbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_take,
  output res_t res
);

  typedef enum logic [9:0] {
    ST_INIT   = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_CALC   = 10'b00_0000_0100,
    ST_APPLY  = 10'b00_0000_1000,
    ST_MERGE  = 10'b00_0001_0000,
    ST_FILL   = 10'b00_0010_0000,
    ST_CLEAR  = 10'b00_0100_0000,
    ST_READ   = 10'b00_1000_0000,
    ST_RDWAIT = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state;

  // latched request
  logic [2:0]       op;
  logic [POS_W-1:0] x_q;
  logic [POS_W-1:0] y_q;
  logic [LEN_W-1:0] w_q;
  logic [LEN_W-1:0] h_q;
  logic [PIX_W-1:0] color_q;

  logic [1:0]        calc_step;
  logic [PROD_W-1:0] prod [4];

  logic             box_valid;
  logic [COL_W-1:0] box_left;
  logic [COL_W-1:0] box_right;
  logic [ROW_W-1:0] box_top;
  logic [ROW_W-1:0] box_bottom;

  logic             rect_live;
  logic [LEN_W-1:0] origin_col;
  logic [LEN_W-1:0] origin_row;
  logic [COL_W-1:0] clip_right;
  logic [ROW_W-1:0] clip_bottom;
  logic [LEN_W-1:0] source_width;
  logic [LEN_W-1:0] source_col;
  logic [LEN_W-1:0] source_row;

  logic [COL_W-1:0]  blk_l;
  logic [COL_W-1:0]  blk_r;
  logic [ROW_W-1:0]  blk_t;
  logic [ROW_W-1:0]  blk_b;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [PIX_W-1:0]  fill_val;
  logic [ADDR_W-1:0] sweep_addr;
  res_t              res_q;

  logic [LEN_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic              calc_last;
  logic              is_pixel;
  logic              is_header;
  logic [WIDE_W-1:0] base_l;
  logic [WIDE_W-1:0] base_t;
  logic [WIDE_W-1:0] span_x;
  logic [WIDE_W-1:0] span_y;
  logic [WIDE_W-1:0] end_r;
  logic [WIDE_W-1:0] end_b;
  logic [WIDE_W-1:0] lim_r;
  logic [WIDE_W-1:0] lim_b;
  logic [WIDE_W-1:0] clip_r_val;
  logic [WIDE_W-1:0] clip_b_val;
  logic [WIDE_W-1:0] next_row_top;
  logic              blk_in;
  logic [LEN_W:0]    col_inc;

  logic [COL_W-1:0] ew_m1;
  logic [ROW_W-1:0] eh_m1;
  logic [POS_W-1:0] req_x;
  logic [POS_W-1:0] req_y;
  logic             hdr_skip;
  logic             rd_ok;
  logic [PIX_W-1:0] req_mono_val;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_q;

  assign ew_m1 = COL_W'(cfg.width - PW_W'(1));
  assign eh_m1 = ROW_W'(cfg.height - PH_W'(1));

  assign req_x        = req.pos_x;
  assign req_y        = req.pos_y;
  assign hdr_skip     = (req.rect_w == '0) || (req.rect_h == '0) ||
                        req_x[POS_W-1] || req_y[POS_W-1];
  assign rd_ok        = !req_x[POS_W-1] && !req_y[POS_W-1] &&
                        (req_x < cfg.width) && (req_y < POS_W'(cfg.height));
  assign req_mono_val = (req.pixel_color != '0) ? PIX_WHITE : PIX_BLACK;

  // shared scale multiplier, one product per cycle
  always_comb begin
    if (op == REQ_PIXEL) begin
      mul_a = calc_step[0] ? source_row : source_col;
    end else begin
      case (calc_step)
        2'd0:    mul_a = x_q;
        2'd1:    mul_a = y_q;
        2'd2:    mul_a = w_q;
        default: mul_a = h_q;
      endcase
    end
  end

  assign mul_p     = PROD_W'(mul_a) * PROD_W'(cfg.scale);
  assign is_pixel  = (op == REQ_PIXEL);
  assign is_header = (op == REQ_HEADER);
  assign calc_last = is_header ? (calc_step == 2'd3) : (calc_step == 2'd1);

  // block corners and clip limits, from the registered products
  assign base_l = is_pixel ? WIDE_W'(origin_col) + WIDE_W'(prod[0]) : WIDE_W'(prod[0]);
  assign base_t = is_pixel ? WIDE_W'(origin_row) + WIDE_W'(prod[1]) : WIDE_W'(prod[1]);
  assign span_x = is_header ? WIDE_W'(prod[2]) : WIDE_W'(cfg.scale);
  assign span_y = is_header ? WIDE_W'(prod[3]) : WIDE_W'(cfg.scale);
  assign end_r  = base_l + span_x - WIDE_W'(1);
  assign end_b  = base_t + span_y - WIDE_W'(1);
  assign lim_r  = is_pixel ? WIDE_W'(clip_right)  : WIDE_W'(ew_m1);
  assign lim_b  = is_pixel ? WIDE_W'(clip_bottom) : WIDE_W'(eh_m1);
  assign blk_in = (base_l <= lim_r) && (base_t <= lim_b);
  assign clip_r_val   = (end_r > lim_r) ? lim_r : end_r;
  assign clip_b_val   = (end_b > lim_b) ? lim_b : end_b;
  assign next_row_top = base_t + WIDE_W'(cfg.scale);
  assign col_inc      = (LEN_W+1)'(source_col) + (LEN_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep_addr <= '0;
      calc_step  <= '0;
      box_valid  <= 1'b0;
      box_left   <= '0;
      box_top    <= '0;
      box_right  <= '0;
      box_bottom <= '0;
      rect_live  <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_valid) begin
            op        <= req.req_type;
            x_q       <= req.pos_x;
            y_q       <= req.pos_y;
            w_q       <= req.rect_w;
            h_q       <= req.rect_h;
            color_q   <= req.pixel_color;
            calc_step <= '0;
            // box as it stood before this beat
            res_q.dirty_valid  <= box_valid;
            res_q.dirty_left   <= box_left;
            res_q.dirty_top    <= box_top;
            res_q.dirty_right  <= box_right;
            res_q.dirty_bottom <= box_bottom;
            res_q.read_data    <= '0;
            case (req.req_type)
              REQ_HEADER: begin
                rect_live <= 1'b0;
                state     <= hdr_skip ? ST_DONE : ST_CALC;
              end
              REQ_PIXEL: begin
                state <= rect_live ? ST_CALC : ST_DONE;
              end
              REQ_MONO: begin
                state <= (req_x[POS_W-1] || req_y[POS_W-1]) ? ST_DONE : ST_CALC;
              end
              REQ_CLEAR: begin
                box_valid  <= 1'b1;
                box_left   <= '0;
                box_top    <= '0;
                box_right  <= ew_m1;
                box_bottom <= eh_m1;
                fill_val   <= req_mono_val;
                sweep_addr <= '0;
                state      <= ST_CLEAR;
              end
              REQ_MARK_ALL: begin
                box_valid  <= 1'b1;
                box_left   <= '0;
                box_top    <= '0;
                box_right  <= ew_m1;
                box_bottom <= eh_m1;
                state      <= ST_DONE;
              end
              REQ_FLUSH: begin
                box_valid  <= 1'b0;
                box_left   <= '0;
                box_top    <= '0;
                box_right  <= '0;
                box_bottom <= '0;
                state      <= ST_DONE;
              end
              REQ_READ: begin
                state <= rd_ok ? ST_READ : ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end

        ST_CALC: begin
          prod[calc_step] <= mul_p;
          calc_step       <= calc_step + 2'd1;
          if (calc_last) begin
            state <= ST_APPLY;
          end
        end

        ST_APPLY: begin
          blk_l <= COL_W'(base_l);
          blk_t <= ROW_W'(base_t);
          blk_r <= COL_W'(clip_r_val);
          blk_b <= ROW_W'(clip_b_val);
          if (is_header && blk_in) begin
            origin_col   <= LEN_W'(base_l);
            origin_row   <= LEN_W'(base_t);
            clip_right   <= COL_W'(clip_r_val);
            clip_bottom  <= ROW_W'(clip_b_val);
            source_width <= w_q;
            source_col   <= '0;
            source_row   <= '0;
            rect_live    <= 1'b1;
          end
          if (is_pixel) begin
            if (col_inc >= (LEN_W+1)'(source_width)) begin
              source_col <= '0;
              source_row <= source_row + LEN_W'(1);
              // next source row starts below the clip window
              if (next_row_top > WIDE_W'(clip_bottom)) begin
                rect_live <= 1'b0;
              end
            end else begin
              source_col <= LEN_W'(col_inc);
            end
          end
          state <= blk_in ? ST_MERGE : ST_DONE;
        end

        ST_MERGE: begin
          box_valid <= 1'b1;
          if (!box_valid) begin
            box_left   <= blk_l;
            box_top    <= blk_t;
            box_right  <= blk_r;
            box_bottom <= blk_b;
          end else begin
            if (blk_l < box_left) begin
              box_left <= blk_l;
            end
            if (blk_t < box_top) begin
              box_top <= blk_t;
            end
            if (blk_r > box_right) begin
              box_right <= blk_r;
            end
            if (blk_b > box_bottom) begin
              box_bottom <= blk_b;
            end
          end
          cur_col  <= blk_l;
          cur_row  <= blk_t;
          fill_val <= is_pixel ? color_q :
                      ((color_q != '0) ? PIX_WHITE : PIX_BLACK);
          state    <= is_header ? ST_DONE : ST_FILL;
        end

        ST_FILL: begin
          if (cur_col == blk_r) begin
            if (cur_row == blk_b) begin
              state <= ST_DONE;
            end else begin
              cur_row <= cur_row + ROW_W'(1);
              cur_col <= blk_l;
            end
          end else begin
            cur_col <= cur_col + COL_W'(1);
          end
        end

        ST_CLEAR: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_DONE;
          end
        end

        ST_READ: begin
          state <= ST_RDWAIT;
        end

        ST_RDWAIT: begin
          res_q.read_data <= rd_data;
          state           <= ST_DONE;
        end

        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign wr_en   = (state == ST_INIT) || (state == ST_CLEAR) || (state == ST_FILL);
  assign wr_addr = (state == ST_FILL) ? {cur_row, cur_col} : sweep_addr;
  assign wr_data = (state == ST_INIT) ? PIX_BLACK : fill_val;
  assign rd_en   = (state == ST_READ);
  assign rd_addr = {y_q[ROW_W-1:0], x_q[COL_W-1:0]};

  sbd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_fill_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cur_col <= blk_r) && (cur_row <= blk_b))
    else $error("fill write outside the clipped block");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box_left <= box_right) && (box_top <= box_bottom))
    else $error("dirty box corners out of order");

  a_box_clean_zero: assert property (@(posedge clk) disable iff (rst)
    !box_valid |-> (box_left == '0) && (box_top == '0) &&
                   (box_right == '0) && (box_bottom == '0))
    else $error("clean dirty box holds stale corners");

  a_rect_origin: assert property (@(posedge clk) disable iff (rst)
    rect_live |-> (origin_col <= LEN_W'(clip_right)) &&
                  (origin_row <= LEN_W'(clip_bottom)))
    else $error("live rectangle origin beyond its clip edge");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != ST_IDLE) && !req_ready)
    else $error("sequencer stayed idle after taking a beat");

endmodule

// File: rtl/scaled_blit_with_dirty_box.sv
// ----------------------------------------------------------------------------
// scaled_blit_with_dirty_box
// Nearest-neighbour upscaling blit into a 1024 x 512 RGB565 framebuffer
// with a dirty bounding box. After reset the framebuffer is cleared by a
// pass over all 524288 words, one word a cycle, during which no request
// beat is taken (register writes are). Every request gives exactly one
// result beat. Mark all dirty, flush, the unused code and requests turned
// away on their raw fields (zero size, negative position, pixel with no
// live rectangle, read off the panel) go straight to their result; read
// waits on the registered framebuffer read; a rectangle header forms four
// scaled products and is dropped when its scaled origin lies off the
// panel; a rectangle or mono pixel forms two, then writes one word per
// position of its block (up to scale squared), or none when the block lies
// outside the clip window; clear sweeps the whole framebuffer. The single
// framebuffer write port takes one word a cycle, and the one shared scale
// multiplier forms one product a cycle. A finished result waits in the
// output register while the next request beat is taken.
// ----------------------------------------------------------------------------
module scaled_blit_with_dirty_box import sbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y, rect_w, rect_h, pixel_color, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [2:0]            s_tuser,
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // dirty_left, dirty_top, dirty_right, dirty_bottom, read_data, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // dirty_valid
  output logic                  m_tuser
);

  localparam int OFS_Y     = POS_W;
  localparam int OFS_W     = 2 * POS_W;
  localparam int OFS_H     = 2 * POS_W + LEN_W;
  localparam int OFS_COLOR = 2 * POS_W + 2 * LEN_W;

  logic [PW_W-1:0]    panel_width;
  logic [PH_W-1:0]    panel_height;
  logic [SCALE_W-1:0] scale;

  cfg_t cfg;
  req_t req;
  res_t res;
  res_t out_q;
  logic res_valid;
  logic out_take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PW_W'(800);
      panel_height <= PH_W'(480);
      scale        <= SCALE_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[APB_ADDR_W-1:2])
        REG_PANEL_WIDTH:  panel_width  <= pwdata[PW_W-1:0];
        REG_PANEL_HEIGHT: panel_height <= pwdata[PH_W-1:0];
        REG_SCALE:        scale        <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[APB_ADDR_W-1:2])
      REG_PANEL_WIDTH:  prdata = APB_DATA_W'(panel_width);
      REG_PANEL_HEIGHT: prdata = APB_DATA_W'(panel_height);
      REG_SCALE:        prdata = APB_DATA_W'(scale);
      default:          prdata = '0;
    endcase
  end

  // limit the registers to the working range
  always_comb begin
    if (panel_width == '0) begin
      cfg.width = PW_W'(1);
    end else if (panel_width > PW_W'(MAX_WIDTH)) begin
      cfg.width = PW_W'(MAX_WIDTH);
    end else begin
      cfg.width = panel_width;
    end
    if (panel_height == '0) begin
      cfg.height = PH_W'(1);
    end else if (panel_height > PH_W'(MAX_HEIGHT)) begin
      cfg.height = PH_W'(MAX_HEIGHT);
    end else begin
      cfg.height = panel_height;
    end
    if (scale == '0) begin
      cfg.scale = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale;
    end
  end

  assign req.req_type    = s_tuser;
  assign req.pos_x       = s_tdata[OFS_Y-1:0];
  assign req.pos_y       = s_tdata[OFS_W-1:OFS_Y];
  assign req.rect_w      = s_tdata[OFS_H-1:OFS_W];
  assign req.rect_h      = s_tdata[OFS_COLOR-1:OFS_H];
  assign req.pixel_color = s_tdata[IN_BITS-1:OFS_COLOR];

  sbd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (out_take),
    .res       (res)
  );

  // output register: the engine moves on once its result beat is parked here
  assign out_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_take) begin
      m_tvalid <= 1'b1;
      out_q    <= res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_q.read_data, out_q.dirty_bottom, out_q.dirty_right,
                                out_q.dirty_top, out_q.dirty_left});
  assign m_tuser = out_q.dirty_valid;

endmodule
